[rtl/letterbox_nearest_scaler_assert.svh]
// Assertion macros for the letterbox scaler RTL.
// Needs no other file; the includer supplies i_clk and i_rst_n.
`ifndef LETTERBOX_NEAREST_SCALER_ASSERT_SVH
`define LETTERBOX_NEAREST_SCALER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define LNSC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define LNSC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/lnsc_pkg.sv]
// Shared types, constants and helper functions for the letterbox scaler.
// Depends on nothing; used by letterbox_nearest_scaler and the testbench.
package lnsc_pkg;

    localparam int COORD_W  = 11;
    localparam int DIM_W    = 12;
    localparam int COLOR_W  = 8;
    localparam int MAX_DIM  = 2048;
    localparam int GRADIENT_FRAC_BITS_DEF = 16;

    localparam logic [DIM_W-1:0] FRAME_WIDTH_RST  = 12'd320;
    localparam logic [DIM_W-1:0] FRAME_HEIGHT_RST = 12'd240;
    localparam logic [DIM_W-1:0] IMAGE_WIDTH_RST  = 12'd1;
    localparam logic [DIM_W-1:0] IMAGE_HEIGHT_RST = 12'd1;

    // Gradient weights, already folded to integers.
    localparam int RED_BASE   = 50;
    localparam int GREEN_BASE = 45;
    localparam int BLUE_BASE  = 55;
    localparam int SLOPE_X    = 60;
    localparam int RED_Y      = 30;
    localparam int GREEN_Y    = 15;
    localparam int BLUE_Y     = 45;

    typedef enum logic [1:0] {
        CFG_FRAME_WIDTH  = 2'd0,
        CFG_FRAME_HEIGHT = 2'd1,
        CFG_IMAGE_WIDTH  = 2'd2,
        CFG_IMAGE_HEIGHT = 2'd3
    } t_cfg_reg;

    typedef struct packed {
        logic [COORD_W-1:0] dest_x;
        logic [COORD_W-1:0] dest_y;
    } t_lnsc_req;

    typedef struct packed {
        logic               inside_image;
        logic [COORD_W-1:0] source_x;
        logic [COORD_W-1:0] source_y;
        logic [COLOR_W-1:0] red;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] blue;
    } t_lnsc_rsp;

    // A zero register acts as one; anything above the maximum saturates.
    function automatic logic [DIM_W-1:0] dim_of(input logic [DIM_W-1:0] r);
        logic [DIM_W-1:0] d;
        if (r == '0) begin
            d = DIM_W'(1);
        end else if (r > DIM_W'(MAX_DIM)) begin
            d = DIM_W'(MAX_DIM);
        end else begin
            d = r;
        end
        return d;
    endfunction

endpackage

[rtl/letterbox_nearest_scaler.sv]
// Top level of the letterbox nearest-neighbor scaler and gradient generator.
// Depends on lnsc_pkg, lnsc_div and letterbox_nearest_scaler_assert.svh.
//
// One request (a destination pixel coordinate) is taken on every clock at which
// start is high; busy is never raised. The result appears on o_result with
// o_valid high for exactly one cycle, and the receiver cannot hold it off. The
// path runs through a chain of pipelined dividers: 12 stages for the fitted
// target size, three stages for offset, bounds and the coordinate product, and
// 11 stages for the source coordinate, plus the input and output registers.
// The gradient path runs beside it and is delayed to match. Register writes
// must only be made while no request is in flight.
`include "letterbox_nearest_scaler_assert.svh"

module letterbox_nearest_scaler #(
    parameter int GRADIENT_FRAC_BITS = lnsc_pkg::GRADIENT_FRAC_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  lnsc_pkg::t_lnsc_req               i_req,
    output logic                              o_valid,
    output lnsc_pkg::t_lnsc_rsp               o_result,
    input  logic                              i_cfg_we,
    input  logic [1:0]                        i_cfg_idx,
    input  logic [lnsc_pkg::DIM_W-1:0]        i_cfg_data
);

    localparam int CW   = lnsc_pkg::COORD_W;
    localparam int DW   = lnsc_pkg::DIM_W;
    localparam int KW   = lnsc_pkg::COLOR_W;
    localparam int F    = GRADIENT_FRAC_BITS;
    localparam int PRW  = 2 * DW;
    localparam int TGNW = PRW + 1;
    localparam int TGDW = DW + 1;
    localparam int SPW  = 2 * CW;
    localparam int SNW  = SPW + 2;
    localparam int SDW  = CW + 1;
    localparam int FQW  = F + 1;
    localparam int FNW  = CW + F;
    localparam int ACCW = F + KW + 1;
    localparam int MAIN_LAT = DW + 3 + CW;
    localparam int DLY  = MAIN_LAT - FQW - 1;

    // ---------------- configuration registers ----------------
    logic [DW-1:0] r_frame_w, r_frame_h, r_image_w, r_image_h;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_w <= lnsc_pkg::FRAME_WIDTH_RST;
            r_frame_h <= lnsc_pkg::FRAME_HEIGHT_RST;
            r_image_w <= lnsc_pkg::IMAGE_WIDTH_RST;
            r_image_h <= lnsc_pkg::IMAGE_HEIGHT_RST;
        end else if (i_cfg_we) begin
            unique case (lnsc_pkg::t_cfg_reg'(i_cfg_idx))
                lnsc_pkg::CFG_FRAME_WIDTH:  r_frame_w <= i_cfg_data;
                lnsc_pkg::CFG_FRAME_HEIGHT: r_frame_h <= i_cfg_data;
                lnsc_pkg::CFG_IMAGE_WIDTH:  r_image_w <= i_cfg_data;
                lnsc_pkg::CFG_IMAGE_HEIGHT: r_image_h <= i_cfg_data;
                default:                    r_image_h <= r_image_h;
            endcase
        end
    end

    logic [DW-1:0] w_dim, h_dim, tw_dim, th_dim, w_m1, h_m1;

    assign w_dim  = lnsc_pkg::dim_of(r_frame_w);
    assign h_dim  = lnsc_pkg::dim_of(r_frame_h);
    assign tw_dim = lnsc_pkg::dim_of(r_image_w);
    assign th_dim = lnsc_pkg::dim_of(r_image_h);
    assign w_m1   = w_dim - DW'(1);
    assign h_m1   = h_dim - DW'(1);

    assign busy = 1'b0;

    // ---------------- stage 1: capture and cross products ----------------
    logic           r1_vld;
    logic [CW-1:0]  r1_x, r1_y;
    logic [PRW-1:0] r1_wth, r1_htw;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else begin
            r1_vld <= start && !busy;
        end
        r1_x   <= i_req.dest_x;
        r1_y   <= i_req.dest_y;
        r1_wth <= PRW'(w_dim) * PRW'(th_dim);
        r1_htw <= PRW'(h_dim) * PRW'(tw_dim);
    end

    // ---------------- target size division ----------------
    logic            fit;
    logic [PRW-1:0]  tg_prod;
    logic [DW-1:0]   tg_den;
    logic [TGNW-1:0] tg_num;
    logic            tg_vld;
    logic [DW-1:0]   tg_q;
    logic [SPW:0]    tg_pay;

    always_comb begin
        fit     = r1_wth <= r1_htw;
        tg_prod = fit ? r1_wth : r1_htw;
        tg_den  = fit ? tw_dim : th_dim;
        tg_num  = {tg_prod, 1'b0} + TGNW'(tg_den);
    end

    lnsc_div #(.NW(TGNW), .DW(TGDW), .QW(DW), .PW(SPW + 1)) u_tg_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r1_vld),
        .i_num   (tg_num),
        .i_den   ({tg_den, 1'b0}),
        .i_pay   ({fit, r1_x, r1_y}),
        .o_vld   (tg_vld),
        .o_quot  (tg_q),
        .o_pay   (tg_pay)
    );

    // ---------------- stage 3: target size and offsets ----------------
    logic [DW-1:0] tg_min, n3_tgw, n3_tgh;
    logic          r3_vld;
    logic [CW-1:0] r3_x, r3_y;
    logic [DW-1:0] r3_tgw, r3_tgh, r3_ox, r3_oy;

    always_comb begin
        tg_min = (tg_q == '0) ? DW'(1) : tg_q;
        n3_tgw = tg_pay[SPW] ? w_dim : tg_min;
        n3_tgh = tg_pay[SPW] ? tg_min : h_dim;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_vld <= 1'b0;
        end else begin
            r3_vld <= tg_vld;
        end
        r3_x   <= tg_pay[SPW-1:CW];
        r3_y   <= tg_pay[CW-1:0];
        r3_tgw <= n3_tgw;
        r3_tgh <= n3_tgh;
        r3_ox  <= (w_dim - n3_tgw) >> 1;
        r3_oy  <= (h_dim - n3_tgh) >> 1;
    end

    // ---------------- stage 4: rectangle test ----------------
    logic [DW-1:0] lx, ly;
    logic          in_x, in_y;
    logic          r4_vld, r4_inside;
    logic [CW-1:0] r4_lx, r4_ly, r4_tgw_m1, r4_tgh_m1;

    always_comb begin
        lx   = DW'(r3_x) - r3_ox;
        ly   = DW'(r3_y) - r3_oy;
        in_x = (DW'(r3_x) >= r3_ox) && (lx < r3_tgw);
        in_y = (DW'(r3_y) >= r3_oy) && (ly < r3_tgh);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_vld <= 1'b0;
        end else begin
            r4_vld <= r3_vld;
        end
        r4_inside <= in_x && in_y;
        r4_lx     <= lx[CW-1:0];
        r4_ly     <= ly[CW-1:0];
        r4_tgw_m1 <= CW'(r3_tgw - DW'(1));
        r4_tgh_m1 <= CW'(r3_tgh - DW'(1));
    end

    // ---------------- stage 5: scale products ----------------
    logic           r5_vld, r5_inside;
    logic [SPW-1:0] r5_px, r5_py;
    logic [CW-1:0]  r5_tgw_m1, r5_tgh_m1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_vld <= 1'b0;
        end else begin
            r5_vld <= r4_vld;
        end
        r5_inside <= r4_inside;
        r5_px     <= SPW'(r4_lx) * SPW'(CW'(tw_dim - DW'(1)));
        r5_py     <= SPW'(r4_ly) * SPW'(CW'(th_dim - DW'(1)));
        r5_tgw_m1 <= r4_tgw_m1;
        r5_tgh_m1 <= r4_tgh_m1;
    end

    // ---------------- source coordinate division ----------------
    logic [SNW-1:0] sx_num, sy_num;
    logic [SDW-1:0] sx_den, sy_den;
    logic           sx_vld, sy_vld, sx_inside, sy_one;
    logic [CW-1:0]  sx_q, sy_q;

    always_comb begin
        sx_num = {r5_px, 1'b0} + SNW'(r5_tgw_m1);
        sy_num = {r5_py, 1'b0} + SNW'(r5_tgh_m1);
        sx_den = (r5_tgw_m1 == '0) ? SDW'(1) : {r5_tgw_m1, 1'b0};
        sy_den = (r5_tgh_m1 == '0) ? SDW'(1) : {r5_tgh_m1, 1'b0};
    end

    lnsc_div #(.NW(SNW), .DW(SDW), .QW(CW), .PW(1)) u_sx_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r5_vld),
        .i_num   (sx_num),
        .i_den   (sx_den),
        .i_pay   (r5_inside),
        .o_vld   (sx_vld),
        .o_quot  (sx_q),
        .o_pay   (sx_inside)
    );

    lnsc_div #(.NW(SNW), .DW(SDW), .QW(CW), .PW(1)) u_sy_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r5_vld),
        .i_num   (sy_num),
        .i_den   (sy_den),
        .i_pay   (r5_tgh_m1 == '0),
        .o_vld   (sy_vld),
        .o_quot  (sy_q),
        .o_pay   (sy_one)
    );

    // ---------------- gradient fractions ----------------
    logic [CW-1:0]  cx_sat, cy_sat, fx_den, fy_den;
    logic           fx_vld, fy_vld, fx_one, fy_one;
    logic [FQW-1:0] fx_q, fy_q;

    always_comb begin
        cx_sat = (DW'(r1_x) > w_m1) ? w_m1[CW-1:0] : r1_x;
        cy_sat = (DW'(r1_y) > h_m1) ? h_m1[CW-1:0] : r1_y;
        fx_den = (w_m1 == '0) ? CW'(1) : w_m1[CW-1:0];
        fy_den = (h_m1 == '0) ? CW'(1) : h_m1[CW-1:0];
    end

    lnsc_div #(.NW(FNW), .DW(CW), .QW(FQW), .PW(1)) u_fx_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r1_vld),
        .i_num   ({cx_sat, F'(0)}),
        .i_den   (fx_den),
        .i_pay   (w_m1 == '0),
        .o_vld   (fx_vld),
        .o_quot  (fx_q),
        .o_pay   (fx_one)
    );

    lnsc_div #(.NW(FNW), .DW(CW), .QW(FQW), .PW(1)) u_fy_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r1_vld),
        .i_num   ({cy_sat, F'(0)}),
        .i_den   (fy_den),
        .i_pay   (h_m1 == '0),
        .o_vld   (fy_vld),
        .o_quot  (fy_q),
        .o_pay   (fy_one)
    );

    // ---------------- gradient colors ----------------
    logic [ACCW-1:0] fx_e, inv_e, acc_r, acc_g, acc_b;
    logic            r_gc_vld;
    logic [3*KW-1:0] r_gc_col;

    always_comb begin
        fx_e  = fx_one ? '0 : ACCW'(fx_q);
        inv_e = (ACCW'(1) << F) - (fy_one ? '0 : ACCW'(fy_q));
        acc_r = (ACCW'(lnsc_pkg::RED_BASE) << F) + ACCW'(lnsc_pkg::SLOPE_X) * fx_e
              + ACCW'(lnsc_pkg::RED_Y) * inv_e;
        acc_g = (ACCW'(lnsc_pkg::GREEN_BASE) << F) + ACCW'(lnsc_pkg::SLOPE_X) * fx_e
              + ACCW'(lnsc_pkg::GREEN_Y) * inv_e;
        acc_b = (ACCW'(lnsc_pkg::BLUE_BASE) << F) + ACCW'(lnsc_pkg::SLOPE_X) * fx_e
              + ACCW'(lnsc_pkg::BLUE_Y) * inv_e;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gc_vld <= 1'b0;
        end else begin
            r_gc_vld <= fx_vld && fy_vld;
        end
        r_gc_col <= {acc_r[F +: KW], acc_g[F +: KW], acc_b[F +: KW]};
    end

    // The gradient finishes early; hold it until the source coordinate is ready.
    logic            grad_vld;
    logic [3*KW-1:0] grad_col;

    if (DLY > 0) begin : g_delay
        logic            r_dl_vld [DLY];
        logic [3*KW-1:0] r_dl_col [DLY];

        for (genvar k = 0; k < DLY; k++) begin : g_tap
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_dl_vld[k] <= 1'b0;
                end else begin
                    r_dl_vld[k] <= (k == 0) ? r_gc_vld : r_dl_vld[(k == 0) ? 0 : k - 1];
                end
                r_dl_col[k] <= (k == 0) ? r_gc_col : r_dl_col[(k == 0) ? 0 : k - 1];
            end
        end

        assign grad_vld = r_dl_vld[DLY-1];
        assign grad_col = r_dl_col[DLY-1];
    end else begin : g_nodelay
        assign grad_vld = r_gc_vld;
        assign grad_col = r_gc_col;
    end

    // ---------------- output register ----------------
    logic                r_out_vld;
    lnsc_pkg::t_lnsc_rsp r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else begin
            r_out_vld <= sx_vld;
        end
        r_out.inside_image <= sx_inside;
        r_out.source_x     <= sx_inside ? sx_q : '0;
        r_out.source_y     <= (sx_inside && !sy_one) ? sy_q : '0;
        r_out.red          <= grad_col[3*KW-1:2*KW];
        r_out.green        <= grad_col[2*KW-1:KW];
        r_out.blue         <= grad_col[KW-1:0];
    end

    assign o_valid  = r_out_vld;
    assign o_result = r_out;

    // ---------------- checks ----------------
    `LNSC_ASSERT_NOW(a_paths_aligned, sx_vld || sy_vld || grad_vld,
        sx_vld && sy_vld && grad_vld, "gradient and source paths out of step")
    `LNSC_ASSERT_NOW(a_target_fits, r3_vld,
        r3_tgw != '0 && r3_tgh != '0 && r3_tgw <= w_dim && r3_tgh <= h_dim,
        "target rectangle does not fit the frame")
    `LNSC_ASSERT_NOW(a_outside_zero, o_valid && !o_result.inside_image,
        o_result.source_x == '0 && o_result.source_y == '0,
        "source coordinate nonzero outside the image")
    `LNSC_ASSERT_NEXT(a_stage_follow, r4_vld, r5_vld, "stage valid lost")

endmodule

[rtl/lnsc_div.sv]
// Pipelined restoring divider, one quotient bit per register stage.
// Uses no package; instantiated by letterbox_nearest_scaler.
module lnsc_div #(
    parameter int NW = 24,
    parameter int DW = 12,
    parameter int QW = 12,
    parameter int PW = 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_vld,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    input  logic [PW-1:0] i_pay,
    output logic          o_vld,
    output logic [QW-1:0] o_quot,
    output logic [PW-1:0] o_pay
);

    // The caller guarantees the quotient fits in QW bits.
    localparam int CW = (NW > DW + QW) ? NW : DW + QW;

    logic          r_vld  [QW];
    logic [NW-1:0] r_rem  [QW];
    logic [DW-1:0] r_den  [QW];
    logic [QW-1:0] r_quot [QW];
    logic [PW-1:0] r_pay  [QW];

    for (genvar k = 0; k < QW; k++) begin : g_stage
        logic          s_vld;
        logic [NW-1:0] s_rem;
        logic [DW-1:0] s_den;
        logic [QW-1:0] s_quot;
        logic [PW-1:0] s_pay;
        logic [CW-1:0] trial;
        logic          take;
        logic [NW-1:0] n_rem;
        logic [QW-1:0] n_quot;

        if (k == 0) begin : g_first
            assign s_vld  = i_vld;
            assign s_rem  = i_num;
            assign s_den  = i_den;
            assign s_quot = '0;
            assign s_pay  = i_pay;
        end else begin : g_next
            assign s_vld  = r_vld[k-1];
            assign s_rem  = r_rem[k-1];
            assign s_den  = r_den[k-1];
            assign s_quot = r_quot[k-1];
            assign s_pay  = r_pay[k-1];
        end

        always_comb begin
            trial  = CW'(s_den) << (QW - 1 - k);
            take   = CW'(s_rem) >= trial;
            n_rem  = take ? NW'(CW'(s_rem) - trial) : s_rem;
            n_quot = s_quot;
            if (take) begin
                n_quot[QW-1-k] = 1'b1;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else begin
                r_vld[k] <= s_vld;
            end
            r_rem[k]  <= n_rem;
            r_den[k]  <= s_den;
            r_quot[k] <= n_quot;
            r_pay[k]  <= s_pay;
        end
    end

    assign o_vld  = r_vld[QW-1];
    assign o_quot = r_quot[QW-1];
    assign o_pay  = r_pay[QW-1];

endmodule

[tb/letterbox_nearest_scaler_checker.sv]
// Checker for the letterbox scaler: mirrors the config registers, predicts each
// response from the accepted request and compares it in order. Depends on lnsc_pkg.
module letterbox_nearest_scaler_checker (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic                 i_busy,
    input  lnsc_pkg::t_lnsc_req  i_req,
    input  logic                 i_valid,
    input  lnsc_pkg::t_lnsc_rsp  i_result,
    input  logic                 i_cfg_we,
    input  logic [1:0]           i_cfg_idx,
    input  logic [11:0]          i_cfg_data,
    output int                   o_fail_count,
    output int                   o_pending,
    output int                   o_seen
);
    import lnsc_pkg::*;

    localparam int FB = GRADIENT_FRAC_BITS_DEF;

    logic [11:0] frame_w_q, frame_h_q, image_w_q, image_h_q;
    t_lnsc_rsp   expected_q[$];

    function automatic longint unsigned clamp_dim(input logic [11:0] r);
        longint unsigned d;
        d = r;
        if (d == 0) d = 1;
        if (d > MAX_DIM) d = MAX_DIM;
        return d;
    endfunction

    function automatic longint unsigned round_div(input longint unsigned n,
                                                  input longint unsigned d);
        return (2 * n + d) / (2 * d);
    endfunction

    function automatic longint unsigned grad_frac(input longint unsigned c,
                                                  input longint unsigned dim);
        longint unsigned cc;
        cc = c;
        if (dim <= 1) return 0;
        if (cc > dim - 1) cc = dim - 1;
        return (cc << FB) / (dim - 1);
    endfunction

    function automatic longint unsigned nearest_src(input longint unsigned l,
                                                    input longint unsigned t,
                                                    input longint unsigned s);
        longint unsigned v;
        if (t <= 1) return 0;
        v = round_div(l * (s - 1), t - 1);
        if (v > s - 1) v = s - 1;
        return v;
    endfunction

    function automatic t_lnsc_rsp predict_pixel(input t_lnsc_req rq);
        longint unsigned w, h, tw, th, tgw, tgh, ox, oy, x, y, fx, fy, one;
        t_lnsc_rsp       r;
        w   = clamp_dim(frame_w_q);
        h   = clamp_dim(frame_h_q);
        tw  = clamp_dim(image_w_q);
        th  = clamp_dim(image_h_q);
        x   = rq.dest_x;
        y   = rq.dest_y;
        one = 64'd1 << FB;
        r   = '0;
        if (w * th <= h * tw) begin
            tgw = w;
            tgh = round_div(th * w, tw);
            if (tgh < 1) tgh = 1;
        end else begin
            tgh = h;
            tgw = round_div(tw * h, th);
            if (tgw < 1) tgw = 1;
        end
        ox = (w - tgw) / 2;
        oy = (h - tgh) / 2;
        if (x < w && y < h && x >= ox && x < ox + tgw && y >= oy && y < oy + tgh) begin
            r.inside_image = 1'b1;
            r.source_x     = 11'(nearest_src(x - ox, tgw, tw));
            r.source_y     = 11'(nearest_src(y - oy, tgh, th));
        end
        fx = grad_frac(x, w);
        fy = grad_frac(y, h);
        r.red   = 8'((RED_BASE * one + SLOPE_X * fx + RED_Y * (one - fy)) >> FB);
        r.green = 8'((GREEN_BASE * one + SLOPE_X * fx + GREEN_Y * (one - fy)) >> FB);
        r.blue  = 8'((BLUE_BASE * one + SLOPE_X * fx + BLUE_Y * (one - fy)) >> FB);
        return r;
    endfunction

    assign o_pending = expected_q.size();

    always @(posedge i_clk) begin
        t_lnsc_rsp e;
        if (!i_rst_n) begin
            frame_w_q    <= FRAME_WIDTH_RST;
            frame_h_q    <= FRAME_HEIGHT_RST;
            image_w_q    <= IMAGE_WIDTH_RST;
            image_h_q    <= IMAGE_HEIGHT_RST;
            o_fail_count <= 0;
            o_seen       <= 0;
            expected_q.delete();
        end else begin
            // Responses are compared before this edge's request is queued.
            if (i_valid) begin
                o_seen <= o_seen + 1;
                if (expected_q.size() == 0) begin
                    if (o_fail_count < 10)
                        $display("ERROR: response with no request pending: %p", i_result);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    e = expected_q.pop_front();
                    if (e !== i_result) begin
                        if (o_fail_count < 10)
                            $display("ERROR: mismatch exp %p got %p", e, i_result);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
            if (i_start && !i_busy)
                expected_q.insert(expected_q.size(), predict_pixel(i_req));
            if (i_cfg_we) begin
                case (t_cfg_reg'(i_cfg_idx))
                    CFG_FRAME_WIDTH:  frame_w_q <= i_cfg_data;
                    CFG_FRAME_HEIGHT: frame_h_q <= i_cfg_data;
                    CFG_IMAGE_WIDTH:  image_w_q <= i_cfg_data;
                    CFG_IMAGE_HEIGHT: image_h_q <= i_cfg_data;
                endcase
            end
        end
    end
endmodule

[tb/letterbox_nearest_scaler_tb.sv]
// Top of the letterbox scaler testbench: clock, reset, config phases and requests.
// Depends on lnsc_pkg, letterbox_nearest_scaler and letterbox_nearest_scaler_checker.
module letterbox_nearest_scaler_tb;
    import lnsc_pkg::*;

    localparam int LIMIT = 400000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    t_lnsc_req   i_req = '0;
    logic        o_valid;
    t_lnsc_rsp   o_result;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_idx = '0;
    logic [11:0] i_cfg_data = '0;
    int          fail_count, pending, seen;
    int          cycle_count = 0;
    int          sent = 0;
    int          inside_hits = 0;

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (o_valid && o_result.inside_image) inside_hits <= inside_hits + 1;
        if (cycle_count > LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    letterbox_nearest_scaler dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy), .i_req(i_req),
        .o_valid(o_valid), .o_result(o_result), .i_cfg_we(i_cfg_we),
        .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data)
    );

    letterbox_nearest_scaler_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start), .i_busy(busy), .i_req(i_req),
        .i_valid(o_valid), .i_result(o_result), .i_cfg_we(i_cfg_we),
        .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data), .o_fail_count(fail_count),
        .o_pending(pending), .o_seen(seen)
    );

    task automatic write_reg(input t_cfg_reg idx, input logic [11:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    task automatic drain_pipe();
        while (pending != 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);
    endtask

    task automatic set_geometry(input logic [11:0] fw, input logic [11:0] fh,
                                input logic [11:0] iw, input logic [11:0] ih);
        drain_pipe();
        write_reg(CFG_FRAME_WIDTH, fw);
        write_reg(CFG_FRAME_HEIGHT, fh);
        write_reg(CFG_IMAGE_WIDTH, iw);
        write_reg(CFG_IMAGE_HEIGHT, ih);
    endtask

    // Holds start high for one accepted request; start stays high across back-to-back
    // requests and only drops for an idle burst.
    task automatic send_pixel(input logic [10:0] x, input logic [10:0] y,
                              input bit allow_idle);
        if (allow_idle && $urandom_range(0, 5) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
        start        <= 1'b1;
        i_req.dest_x <= x;
        i_req.dest_y <= y;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        sent++;
    endtask

    task automatic random_dim(output logic [11:0] d);
        case ($urandom_range(0, 9))
            0:       d = 12'(0);
            1:       d = 12'(1);
            2:       d = 12'(MAX_DIM);
            3:       d = 12'($urandom_range(MAX_DIM + 1, 4095));
            4, 5:    d = 12'($urandom_range(1, 16));
            default: d = 12'($urandom_range(1, 400));
        endcase
    endtask

    // Mostly coordinates inside the frame, some beyond it.
    task automatic random_pixels(input int n, input bit allow_idle);
        int w, h;
        w = (u_checker.frame_w_q == 0) ? 1 : (u_checker.frame_w_q > MAX_DIM ? MAX_DIM
            : u_checker.frame_w_q);
        h = (u_checker.frame_h_q == 0) ? 1 : (u_checker.frame_h_q > MAX_DIM ? MAX_DIM
            : u_checker.frame_h_q);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 9) == 0)
                send_pixel(11'($urandom), 11'($urandom), allow_idle);
            else
                send_pixel(11'($urandom_range(0, w - 1)), 11'($urandom_range(0, h - 1)),
                           allow_idle);
        end
        start <= 1'b0;
        @(posedge i_clk);
    endtask

    initial begin
        logic [11:0] fw, fh, iw, ih;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: reset geometry and several fixed geometries, corners and out-of-frame coordinates.
        send_pixel(0, 0, 0);
        send_pixel(319, 239, 0);
        send_pixel(160, 120, 0);
        send_pixel(2047, 2047, 0);
        send_pixel(400, 5, 0);
        start <= 1'b0;
        set_geometry(2048, 2048, 2048, 1);
        send_pixel(0, 1023, 0);
        send_pixel(2047, 1024, 0);
        send_pixel(1024, 0, 0);
        start <= 1'b0;
        set_geometry(0, 0, 0, 0);
        send_pixel(0, 0, 0);
        send_pixel(1, 1, 0);
        start <= 1'b0;
        set_geometry(4095, 3000, 1, 4095);
        send_pixel(1023, 0, 0);
        send_pixel(1024, 2047, 0);
        send_pixel(2047, 0, 0);
        start <= 1'b0;
        set_geometry(7, 640, 3, 5);
        send_pixel(0, 320, 0);
        send_pixel(6, 323, 0);
        send_pixel(3, 2047, 0);
        start <= 1'b0;
        @(posedge i_clk);

        for (int ph = 0; ph < 30; ph++) begin
            random_dim(fw);
            random_dim(fh);
            random_dim(iw);
            random_dim(ih);
            set_geometry(fw, fh, iw, ih);
            random_pixels(60, ph < 26);
        end

        drain_pipe();
        $display("Sent %0d requests over 35 geometry settings, %0d responses checked,",
                 sent, seen);
        $display("%0d of them inside the fitted image.", inside_hits);
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule
